@@ rtl/bpt_pkg.sv @@
// Package for the barycentric point-in-triangle pipeline.
// Holds the weight format and the digit width of the staged multipliers.
// No dependencies.
package bpt_pkg;

    localparam int WEIGHT_W  = 32;
    localparam int MUL_DIGIT = 16;

    typedef logic signed [WEIGHT_W-1:0] weight_t;

    localparam weight_t WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam weight_t WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

endpackage

@@ rtl/bpt_if.sv @@
// Valid/ready channel interfaces for the query beat and the result beat.
// Depends on bpt_pkg.
interface bpt_query_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] corner_a_x;
    logic signed [COORD_WIDTH-1:0] corner_a_y;
    logic signed [COORD_WIDTH-1:0] corner_a_z;
    logic signed [COORD_WIDTH-1:0] corner_b_x;
    logic signed [COORD_WIDTH-1:0] corner_b_y;
    logic signed [COORD_WIDTH-1:0] corner_b_z;
    logic signed [COORD_WIDTH-1:0] corner_c_x;
    logic signed [COORD_WIDTH-1:0] corner_c_y;
    logic signed [COORD_WIDTH-1:0] corner_c_z;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source
    (
        output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
               corner_b_z, corner_c_x, corner_c_y, corner_c_z, point_x, point_y,
               point_z,
        input  ready
    );
    modport sink
    (
        input  valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
               corner_b_z, corner_c_x, corner_c_y, corner_c_z, point_x, point_y,
               point_z,
        output ready
    );
endinterface

interface bpt_result_if import bpt_pkg::*; ();
    logic    valid;
    logic    ready;
    weight_t weight_u;
    weight_t weight_v;
    weight_t weight_w;
    logic    inside_res;
    logic    degenerate;

    modport source
    (
        output valid, weight_u, weight_v, weight_w, inside_res, degenerate,
        input  ready
    );
    modport sink
    (
        input  valid, weight_u, weight_v, weight_w, inside_res, degenerate,
        output ready
    );
endinterface

@@ rtl/barycentric_point_in_triangle.sv @@
// Top level of the barycentric point-in-triangle pipeline.
// Depends on bpt_pkg, bpt_if, bpt_mul and bpt_div.
//
//   channel  dir  beat contents
//   query    in   corners a, b, c and point, x/y/z each, signed Q16.16
//   result   out  weights u, v, w (Q16.16, saturated), inside_res, degenerate
//
// One query beat per cycle is taken while result is not stalled; the pipeline depth
// is set by the digit stages of the two multiplier rows and the one-bit-per-stage dividers.
// Reset clears only the valid bits; the data stages need none.
// A stall on result freezes the whole pipeline; query.ready drops only while the
// output register holds a beat that is not taken.
module barycentric_point_in_triangle import bpt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    bpt_query_if.sink    query,
    bpt_result_if.source result
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int PW1  = 2 * DW;
    localparam int DOTW = PW1 + 2;
    localparam int PW2  = 2 * DOTW;
    localparam int NW   = PW2 + 3;
    localparam int LM1  = (DW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int LM2  = (DOTW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int LD   = WEIGHT_W + 2;
    localparam int TOT  = 6 + LM1 + LM2 + LD;

    localparam int DOT_ABAB = 0;
    localparam int DOT_ABAC = 1;
    localparam int DOT_ACAC = 2;
    localparam int DOT_APAB = 3;
    localparam int DOT_APAC = 4;

    logic           adv;
    logic [TOT-1:0] vld_reg;
    logic [TOT-1:0] vld_next;

    assign adv         = ~vld_reg[TOT-1] | result.ready;
    assign query.ready = adv;
    assign vld_next    = {vld_reg[TOT-2:0], query.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // edge vectors
    logic signed [CW-1:0] a_in [3];
    logic signed [CW-1:0] b_in [3];
    logic signed [CW-1:0] c_in [3];
    logic signed [CW-1:0] p_in [3];
    logic signed [DW-1:0] ab_reg [3];
    logic signed [DW-1:0] ac_reg [3];
    logic signed [DW-1:0] ap_reg [3];

    assign a_in[0] = query.corner_a_x;
    assign a_in[1] = query.corner_a_y;
    assign a_in[2] = query.corner_a_z;
    assign b_in[0] = query.corner_b_x;
    assign b_in[1] = query.corner_b_y;
    assign b_in[2] = query.corner_b_z;
    assign c_in[0] = query.corner_c_x;
    assign c_in[1] = query.corner_c_y;
    assign c_in[2] = query.corner_c_z;
    assign p_in[0] = query.point_x;
    assign p_in[1] = query.point_y;
    assign p_in[2] = query.point_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i] <= DW'(b_in[i]) - DW'(a_in[i]);
                ac_reg[i] <= DW'(c_in[i]) - DW'(a_in[i]);
                ap_reg[i] <= DW'(p_in[i]) - DW'(a_in[i]);
            end
        end
    end

    // first multiplier row: fifteen coordinate products
    logic signed [DW-1:0]  m1_a [15];
    logic signed [DW-1:0]  m1_b [15];
    logic signed [PW1-1:0] pr1  [15];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            m1_a[3*DOT_ABAB+c] = ab_reg[c];
            m1_b[3*DOT_ABAB+c] = ab_reg[c];
            m1_a[3*DOT_ABAC+c] = ab_reg[c];
            m1_b[3*DOT_ABAC+c] = ac_reg[c];
            m1_a[3*DOT_ACAC+c] = ac_reg[c];
            m1_b[3*DOT_ACAC+c] = ac_reg[c];
            m1_a[3*DOT_APAB+c] = ap_reg[c];
            m1_b[3*DOT_APAB+c] = ab_reg[c];
            m1_a[3*DOT_APAC+c] = ap_reg[c];
            m1_b[3*DOT_APAC+c] = ac_reg[c];
        end
    end

    for (genvar j = 0; j < 15; j++)
    begin : g_mul1
        bpt_mul #(.AW(DW), .BW(DW)) u_mul
        (
            .clk (clk),
            .adv (adv),
            .a   (m1_a[j]),
            .b   (m1_b[j]),
            .p   (pr1[j])
        );
    end

    // dot products
    logic signed [DOTW-1:0] dot_reg [5];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < 5; d++)
            begin
                dot_reg[d] <= DOTW'(pr1[3*d]) + DOTW'(pr1[3*d+1]) + DOTW'(pr1[3*d+2]);
            end
        end
    end

    // second multiplier row: determinant and numerator terms
    logic signed [DOTW-1:0] m2_a [6];
    logic signed [DOTW-1:0] m2_b [6];
    logic signed [PW2-1:0]  pr2  [6];

    assign m2_a[0] = dot_reg[DOT_ABAB];
    assign m2_b[0] = dot_reg[DOT_ACAC];
    assign m2_a[1] = dot_reg[DOT_ABAC];
    assign m2_b[1] = dot_reg[DOT_ABAC];
    assign m2_a[2] = dot_reg[DOT_ACAC];
    assign m2_b[2] = dot_reg[DOT_APAB];
    assign m2_a[3] = dot_reg[DOT_ABAC];
    assign m2_b[3] = dot_reg[DOT_APAC];
    assign m2_a[4] = dot_reg[DOT_ABAB];
    assign m2_b[4] = dot_reg[DOT_APAC];
    assign m2_a[5] = dot_reg[DOT_ABAC];
    assign m2_b[5] = dot_reg[DOT_APAB];

    for (genvar j = 0; j < 6; j++)
    begin : g_mul2
        bpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul
        (
            .clk (clk),
            .adv (adv),
            .a   (m2_a[j]),
            .b   (m2_b[j]),
            .p   (pr2[j])
        );
    end

    logic signed [NW-1:0] det_reg;
    logic signed [NW-1:0] nv_reg;
    logic signed [NW-1:0] nw_reg;
    logic signed [NW-1:0] det2_reg;
    logic signed [NW-1:0] nu2_reg;
    logic signed [NW-1:0] nv2_reg;
    logic signed [NW-1:0] nw2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg  <= NW'(pr2[0]) - NW'(pr2[1]);
            nv_reg   <= NW'(pr2[2]) - NW'(pr2[3]);
            nw_reg   <= NW'(pr2[4]) - NW'(pr2[5]);
            det2_reg <= det_reg;
            nu2_reg  <= det_reg - nv_reg - nw_reg;
            nv2_reg  <= nv_reg;
            nw2_reg  <= nw_reg;
        end
    end

    // magnitudes and quotient signs
    logic [NW-1:0] umag_reg;
    logic [NW-1:0] vmag_reg;
    logic [NW-1:0] wmag_reg;
    logic [NW-1:0] dmag_reg;
    logic          uneg_reg;
    logic          vneg_reg;
    logic          wneg_reg;
    logic          degen_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            umag_reg  <= nu2_reg[NW-1]  ? NW'(-nu2_reg)  : NW'(nu2_reg);
            vmag_reg  <= nv2_reg[NW-1]  ? NW'(-nv2_reg)  : NW'(nv2_reg);
            wmag_reg  <= nw2_reg[NW-1]  ? NW'(-nw2_reg)  : NW'(nw2_reg);
            dmag_reg  <= det2_reg[NW-1] ? NW'(-det2_reg) : NW'(det2_reg);
            uneg_reg  <= nu2_reg[NW-1] ^ det2_reg[NW-1];
            vneg_reg  <= nv2_reg[NW-1] ^ det2_reg[NW-1];
            wneg_reg  <= nw2_reg[NW-1] ^ det2_reg[NW-1];
            degen_reg <= (det2_reg == '0);
        end
    end

    weight_t u_div;
    weight_t v_div;
    weight_t w_div;

    bpt_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_u
    (
        .clk     (clk),
        .adv     (adv),
        .num_mag (umag_reg),
        .den_mag (dmag_reg),
        .neg     (uneg_reg),
        .zero    (degen_reg),
        .weight  (u_div)
    );

    bpt_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_v
    (
        .clk     (clk),
        .adv     (adv),
        .num_mag (vmag_reg),
        .den_mag (dmag_reg),
        .neg     (vneg_reg),
        .zero    (degen_reg),
        .weight  (v_div)
    );

    bpt_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_w
    (
        .clk     (clk),
        .adv     (adv),
        .num_mag (wmag_reg),
        .den_mag (dmag_reg),
        .neg     (wneg_reg),
        .zero    (degen_reg),
        .weight  (w_div)
    );

    // carry the degenerate flag alongside the dividers
    logic [LD-1:0] degen_dly_reg;
    logic [LD-1:0] degen_dly_next;

    assign degen_dly_next = {degen_dly_reg[LD-2:0], degen_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            degen_dly_reg <= degen_dly_next;
        end
    end

    weight_t out_u_reg;
    weight_t out_v_reg;
    weight_t out_w_reg;
    logic    out_inside_reg;
    logic    out_degen_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_u_reg      <= u_div;
            out_v_reg      <= v_div;
            out_w_reg      <= w_div;
            out_inside_reg <= ~degen_dly_reg[LD-1]
                              & ~u_div[WEIGHT_W-1] & ~v_div[WEIGHT_W-1] & ~w_div[WEIGHT_W-1];
            out_degen_reg  <= degen_dly_reg[LD-1];
        end
    end

    assign result.valid      = vld_reg[TOT-1];
    assign result.weight_u   = out_u_reg;
    assign result.weight_v   = out_v_reg;
    assign result.weight_w   = out_w_reg;
    assign result.inside_res = out_inside_reg;
    assign result.degenerate = out_degen_reg;

endmodule

@@ rtl/bpt_mul.sv @@
// Staged signed multiplier: one MUL_DIGIT-bit digit of b per register stage.
// Depends on bpt_pkg.
module bpt_mul import bpt_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 33
)
(
    input  logic                    clk,
    input  logic                    adv,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int PW  = AW + BW;
    localparam int NCH = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BX  = NCH * MUL_DIGIT;
    localparam int PPW = AW + MUL_DIGIT + 1;

    logic signed [AW-1:0] a_reg   [NCH-1];
    logic signed [BX-1:0] b_reg   [NCH-1];
    logic signed [PW-1:0] acc_reg [NCH];
    logic signed [AW-1:0] a_st    [NCH];
    logic signed [BX-1:0] b_st    [NCH];
    logic signed [PW-1:0] acc_st  [NCH];
    logic signed [PW-1:0] acc_next[NCH];

    for (genvar k = 0; k < NCH; k++)
    begin : g_stage
        logic signed [MUL_DIGIT:0] dig;
        logic signed [PPW-1:0]     pp;

        if (k == 0)
        begin : g_first
            assign a_st[k]   = a;
            assign b_st[k]   = BX'(b);
            assign acc_st[k] = '0;
        end
        else
        begin : g_rest
            assign a_st[k]   = a_reg[k-1];
            assign b_st[k]   = b_reg[k-1];
            assign acc_st[k] = acc_reg[k-1];
        end

        // top digit carries the sign, the others are unsigned
        if (k == NCH - 1)
        begin : g_top
            assign dig = {b_st[k][BX-1], b_st[k][k*MUL_DIGIT +: MUL_DIGIT]};
        end
        else
        begin : g_low
            assign dig = {1'b0, b_st[k][k*MUL_DIGIT +: MUL_DIGIT]};
        end

        assign pp          = a_st[k] * dig;
        assign acc_next[k] = acc_st[k] + (PW'(pp) <<< (k * MUL_DIGIT));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                acc_reg[k] <= acc_next[k];
            end
        end

        if (k < NCH - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    a_reg[k] <= a_st[k];
                    b_reg[k] <= b_st[k];
                end
            end
        end
    end

    assign p = acc_reg[NCH-1];

endmodule

@@ rtl/bpt_div.sv @@
// Pipelined restoring divider: floor(N * 2^FRAC_BITS / D) from sign and magnitudes,
// one quotient bit per stage, saturated to a weight. Depends on bpt_pkg.
module bpt_div import bpt_pkg::*;
#(
    parameter int NW        = 139,
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          adv,
    input  logic [NW-1:0] num_mag,
    input  logic [NW-1:0] den_mag,
    input  logic          neg,
    input  logic          zero,
    output weight_t       weight
);

    localparam int XW = NW + WEIGHT_W;

    logic [XW-1:0]       rem_reg  [WEIGHT_W+1];
    logic [NW-1:0]       den_reg  [WEIGHT_W];
    logic                neg_reg  [WEIGHT_W+1];
    logic                zero_reg [WEIGHT_W+1];
    logic                ovf_reg  [WEIGHT_W+1];
    logic [WEIGHT_W-1:0] q_reg    [1:WEIGHT_W];
    weight_t             weight_reg;

    logic [XW-1:0] x_shift;
    logic [XW-1:0] den_top;

    // quotient of 2^WEIGHT_W or more saturates either way
    assign x_shift = XW'(num_mag) << FRAC_BITS;
    assign den_top = {den_mag, {WEIGHT_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= x_shift;
            den_reg[0]  <= den_mag;
            neg_reg[0]  <= neg;
            zero_reg[0] <= zero;
            ovf_reg[0]  <= (x_shift >= den_top);
        end
    end

    for (genvar s = 1; s <= WEIGHT_W; s++)
    begin : g_step
        logic [XW:0]         trial;
        logic                take;
        logic [WEIGHT_W-1:0] q_st;
        logic [XW-1:0]       rem_next;
        logic [WEIGHT_W-1:0] q_next;

        if (s == 1)
        begin : g_q0
            assign q_st = '0;
        end
        else
        begin : g_qn
            assign q_st = q_reg[s-1];
        end

        assign trial    = {1'b0, rem_reg[s-1]}
                        - {1'b0, XW'(den_reg[s-1]) << (WEIGHT_W - s)};
        assign take     = ~trial[XW];
        assign rem_next = take ? trial[XW-1:0] : rem_reg[s-1];
        assign q_next   = {q_st[WEIGHT_W-2:0], take};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
            end
        end

        if (s < WEIGHT_W)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    logic [WEIGHT_W-1:0] q_fin;
    logic                inexact;
    logic [WEIGHT_W:0]   q_inc;
    logic                neg_over;
    weight_t             weight_next;

    assign q_fin    = q_reg[WEIGHT_W];
    assign inexact  = |rem_reg[WEIGHT_W];
    assign q_inc    = {1'b0, q_fin} + {{WEIGHT_W{1'b0}}, inexact};
    assign neg_over = q_inc[WEIGHT_W] | (q_inc[WEIGHT_W-1] & (|q_inc[WEIGHT_W-2:0]));

    // floor for a negative quotient: step one further down when inexact
    always_comb
    begin
        if (zero_reg[WEIGHT_W])
        begin
            weight_next = '0;
        end
        else if (!neg_reg[WEIGHT_W])
        begin
            weight_next = (ovf_reg[WEIGHT_W] || q_fin[WEIGHT_W-1]) ? WEIGHT_MAX
                                                                  : weight_t'(q_fin);
        end
        else
        begin
            weight_next = (ovf_reg[WEIGHT_W] || neg_over) ? WEIGHT_MIN
                                                         : weight_t'(-q_inc[WEIGHT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule
